// ===== rtl/core/hue_wheel_colormap_assert.svh =====
// ---------------------------------------------------------------------------
// Hue wheel colormap assertion macros
// Shared property forms for the checker of the hue wheel colormap.
// ---------------------------------------------------------------------------
`ifndef HUE_WHEEL_COLORMAP_ASSERT_SVH
`define HUE_WHEEL_COLORMAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HWC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hwc_pkg.sv =====
// ---------------------------------------------------------------------------
// Hue wheel colormap package
// Widths, constants, the hue segment codes and the color word layout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hwc_pkg;

    // Field widths.
    localparam int COUNT_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int CHAN_W   = 8;
    // Width of six times a remainder, and of 255 times a ramp numerator.
    localparam int SIX_W    = PERIOD_W + 3;
    localparam int SCALED_W = PERIOD_W + CHAN_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd256;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd1;
    localparam logic [CHAN_W-1:0]   CHAN_FULL    = 8'hFF;
    localparam logic [CHAN_W-1:0]   CHAN_OFF     = 8'h00;

    // Hue segments in wheel order, named by the channel that ramps.
    typedef enum logic [2:0] {
        SEG_GREEN_UP   = 3'd0,
        SEG_BLUE_DOWN  = 3'd1,
        SEG_RED_UP     = 3'd2,
        SEG_GREEN_DOWN = 3'd3,
        SEG_BLUE_UP    = 3'd4,
        SEG_RED_DOWN   = 3'd5
    } seg_t;

    // Color word, red in the lowest byte.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

endpackage

// ===== rtl/core/hwc_mod.sv =====
// ---------------------------------------------------------------------------
// Hue wheel colormap remainder pipeline
// Computes count mod period with one restoring step per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwc_mod
    import hwc_pkg::*;
#(
    parameter int CNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [CNT_BITS-1:0] in_count,
    input  logic [PERIOD_W-1:0] period,
    output logic                out_valid,
    output logic [PERIOD_W-1:0] out_rem
);

    logic                vld_reg  [CNT_BITS];
    logic [PERIOD_W-1:0] rem_reg  [CNT_BITS];
    logic [CNT_BITS-1:0] cnt_reg  [CNT_BITS];
    logic [PERIOD_W-1:0] rem_next [CNT_BITS];
    logic [CNT_BITS-1:0] cnt_next [CNT_BITS];

    genvar i;
    generate
        for (i = 0; i < CNT_BITS; i++) begin : g_stage
            logic                vld_in;
            logic [PERIOD_W-1:0] rem_in;
            logic [CNT_BITS-1:0] cnt_in;
            logic [PERIOD_W:0]   trial;
            logic [PERIOD_W:0]   diff;

            // The first stage starts from a zero remainder.
            if (i == 0) begin : g_first
                assign vld_in = in_valid;
                assign rem_in = '0;
                assign cnt_in = in_count;
            end
            else begin : g_rest
                assign vld_in = vld_reg[i-1];
                assign rem_in = rem_reg[i-1];
                assign cnt_in = cnt_reg[i-1];
            end

            // Shift in the next count bit and subtract the period if it fits.
            assign trial       = {rem_in, cnt_in[CNT_BITS-1]};
            assign diff        = trial - {1'b0, period};
            assign rem_next[i] = (trial >= {1'b0, period}) ? diff[PERIOD_W-1:0]
                                                           : trial[PERIOD_W-1:0];
            assign cnt_next[i] = {cnt_in[CNT_BITS-2:0], 1'b0};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next[i];
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[CNT_BITS-1];
    assign out_rem   = rem_reg[CNT_BITS-1];

endmodule

// ===== rtl/core/hwc_div.sv =====
// ---------------------------------------------------------------------------
// Hue wheel colormap ramp divider
// Divides the scaled ramp numerator by the period, one quotient bit a stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwc_div
    import hwc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SCALED_W-1:0] in_num,
    input  seg_t                in_seg,
    input  logic [PERIOD_W-1:0] period,
    output logic                out_valid,
    output logic [CHAN_W-1:0]   out_quot,
    output seg_t                out_seg
);

    logic                vld_reg  [CHAN_W];
    logic [SCALED_W-1:0] rem_reg  [CHAN_W];
    logic [CHAN_W-1:0]   quot_reg [CHAN_W];
    seg_t                seg_reg  [CHAN_W];
    logic [SCALED_W-1:0] rem_next [CHAN_W];
    logic [CHAN_W-1:0]   quot_next[CHAN_W];

    genvar i;
    generate
        for (i = 0; i < CHAN_W; i++) begin : g_stage
            localparam int SHIFT = CHAN_W - 1 - i;
            logic                vld_in;
            logic [SCALED_W-1:0] rem_in;
            logic [CHAN_W-1:0]   quot_in;
            seg_t                seg_in;
            logic [SCALED_W-1:0] divisor;
            logic                fits;

            if (i == 0) begin : g_first
                assign vld_in  = in_valid;
                assign rem_in  = in_num;
                assign quot_in = '0;
                assign seg_in  = in_seg;
            end
            else begin : g_rest
                assign vld_in  = vld_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign quot_in = quot_reg[i-1];
                assign seg_in  = seg_reg[i-1];
            end

            // Try the period scaled to this quotient bit.
            assign divisor = {{CHAN_W{1'b0}}, period} << SHIFT;
            assign fits    = (rem_in >= divisor);

            always_comb
            begin
                rem_next[i]  = rem_in;
                quot_next[i] = quot_in;
                if (fits)
                begin
                    rem_next[i]         = rem_in - divisor;
                    quot_next[i][SHIFT] = 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= rem_next[i];
                    quot_reg[i] <= quot_next[i];
                    seg_reg[i]  <= seg_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[CHAN_W-1];
    assign out_quot  = quot_reg[CHAN_W-1];
    assign out_seg   = seg_reg[CHAN_W-1];

endmodule

// ===== rtl/core/hue_wheel_colormap.sv =====
// ---------------------------------------------------------------------------
// Hue wheel colormap
// The block turns each count word into one RGB word on a six-segment hue
// wheel whose full turn spans the period register (a written zero acts as
// one). It takes a word in every clock cycle while the output is not
// stalled and returns the colors in order. The pipeline holds the remainder
// pipeline, one stage per count bit, and the ramp divider, one stage per
// color bit. The whole pipeline advances together, so ready falls only
// while a finished color waits on the output.
// Write the period only when no word is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hue_wheel_colormap
    import hwc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration.
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    // Count stream.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [COUNT_W-1:0]  s_axis_tdata,  // [15:0] count
    // Color stream.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

    localparam int CW = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;

    logic                adv;
    logic [PERIOD_W-1:0] period_reg;
    logic [SIX_W-1:0]    mult_reg  [6];
    logic [SIX_W-1:0]    mult_next [6];
    logic [SIX_W-1:0]    p_ext;

    logic                mod_valid;
    logic [PERIOD_W-1:0] mod_rem;

    logic                s1_valid_reg;
    logic [SIX_W-1:0]    s1_six_reg;
    seg_t                s1_seg_reg;
    logic [SIX_W-1:0]    six_next;
    logic [2:0]          seg_next;

    logic                s2_valid_reg;
    logic [PERIOD_W-1:0] s2_num_reg;
    seg_t                s2_seg_reg;
    logic [SIX_W-1:0]    num_next;

    logic                s3_valid_reg;
    logic [SCALED_W-1:0] s3_scaled_reg;
    seg_t                s3_seg_reg;

    logic                div_valid;
    logic [CHAN_W-1:0]   div_quot;
    seg_t                div_seg;

    logic                out_valid_reg;
    rgb_t                out_rgb_reg;
    rgb_t                rgb_next;

    // The pipeline moves as one while the output word is free or taken.
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Period register; zero is stored as one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            period_reg <= (cfg_wr_data == '0) ? PERIOD_MIN : cfg_wr_data;
        end
    end

    // Multiples of the period, one to six, for the segment bounds.
    assign p_ext        = {3'b000, period_reg};
    assign mult_next[0] = p_ext;
    assign mult_next[1] = p_ext << 1;
    assign mult_next[2] = p_ext + (p_ext << 1);
    assign mult_next[3] = p_ext << 2;
    assign mult_next[4] = p_ext + (p_ext << 2);
    assign mult_next[5] = (p_ext << 2) + (p_ext << 1);

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            mult_reg[j] <= mult_next[j];
        end
    end

    // Remainder of the count by the period.
    hwc_mod #(
        .CNT_BITS (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_axis_tvalid),
        .in_count  (s_axis_tdata[CW-1:0]),
        .period    (period_reg),
        .out_valid (mod_valid),
        .out_rem   (mod_rem)
    );

    // Stage 1: six times the remainder and its segment.
    assign six_next = ({3'b000, mod_rem} << 2) + ({3'b000, mod_rem} << 1);
    assign seg_next = {2'b00, (six_next > mult_reg[0])}
                    + {2'b00, (six_next > mult_reg[1])}
                    + {2'b00, (six_next > mult_reg[2])}
                    + {2'b00, (six_next > mult_reg[3])}
                    + {2'b00, (six_next > mult_reg[4])};

    // Stage 2: ramp numerator, distance from the segment's lower or upper bound.
    always_comb
    begin
        case (s1_seg_reg)
            SEG_GREEN_UP:   num_next = s1_six_reg;
            SEG_BLUE_DOWN:  num_next = mult_reg[1] - s1_six_reg;
            SEG_RED_UP:     num_next = s1_six_reg - mult_reg[1];
            SEG_GREEN_DOWN: num_next = mult_reg[3] - s1_six_reg;
            SEG_BLUE_UP:    num_next = s1_six_reg - mult_reg[3];
            default:        num_next = mult_reg[5] - s1_six_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= mod_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 3 scales the numerator by 255.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_six_reg    <= six_next;
            s1_seg_reg    <= seg_t'(seg_next);
            s2_num_reg    <= num_next[PERIOD_W-1:0];
            s2_seg_reg    <= s1_seg_reg;
            s3_scaled_reg <= {s2_num_reg, CHAN_OFF} - {CHAN_OFF, s2_num_reg};
            s3_seg_reg    <= s2_seg_reg;
        end
    end

    // Ramp value: scaled numerator over the period.
    hwc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .in_num    (s3_scaled_reg),
        .in_seg    (s3_seg_reg),
        .period    (period_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_seg   (div_seg)
    );

    // Place the ramp and the fixed channels by segment.
    always_comb
    begin
        case (div_seg)
            SEG_GREEN_UP:   rgb_next = '{blue: CHAN_FULL, green: div_quot,  red: CHAN_OFF};
            SEG_BLUE_DOWN:  rgb_next = '{blue: div_quot,  green: CHAN_FULL, red: CHAN_OFF};
            SEG_RED_UP:     rgb_next = '{blue: CHAN_OFF,  green: CHAN_FULL, red: div_quot};
            SEG_GREEN_DOWN: rgb_next = '{blue: CHAN_OFF,  green: div_quot,  red: CHAN_FULL};
            SEG_BLUE_UP:    rgb_next = '{blue: div_quot,  green: CHAN_OFF,  red: CHAN_FULL};
            default:        rgb_next = '{blue: CHAN_FULL, green: CHAN_OFF,  red: div_quot};
        endcase
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_rgb_reg <= rgb_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_rgb_reg;

endmodule

// ===== rtl/core/hwc_checker.sv =====
// ---------------------------------------------------------------------------
// Hue wheel colormap checker
// Port-level assertions on the count and color streams, bound to the top level.
// ---------------------------------------------------------------------------
`include "hue_wheel_colormap_assert.svh"
`timescale 1ns / 1ps

module hwc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic out_stall;
    logic ready_ok;
    logic has_full;
    logic has_off;
    logic out_known;

    // Short names for the conditions the assertions check.
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign ready_ok  = (s_axis_tready == (!m_axis_tvalid || m_axis_tready));
    assign has_full  = (m_axis_tdata[7:0] == 8'hFF) || (m_axis_tdata[15:8] == 8'hFF)
                    || (m_axis_tdata[23:16] == 8'hFF);
    assign has_off   = (m_axis_tdata[7:0] == 8'h00) || (m_axis_tdata[15:8] == 8'h00)
                    || (m_axis_tdata[23:16] == 8'h00);
    assign out_known = !$isunknown(m_axis_tdata);

    // A stalled color word stays offered.
    `HWC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid, "stalled word dropped")

    // A stalled color word keeps its value.
    `HWC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(m_axis_tdata), "stalled word changed")

    // The input side waits only while the output word is stalled.
    `HWC_ASSERT_SAME(a_ready_link, clk, rst_n, 1'b1, ready_ok, "input stalled without backpressure")

    // Every color has one channel at full and one channel off.
    `HWC_ASSERT_SAME(a_hue_shape, clk, rst_n, m_axis_tvalid, has_full && has_off, "color off the wheel")

    // An offered color word carries no unknown bits.
    `HWC_ASSERT_SAME(a_out_known, clk, rst_n, m_axis_tvalid, out_known, "unknown color bits")

endmodule

bind hue_wheel_colormap hwc_checker u_hwc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_hue_wheel_colormap.sv =====
// ---------------------------------------------------------------------------
// Hue wheel colormap testbench
// Streams count words through the colormap under several period settings.
// An in-bench model predicts each color the table does not type; the table runs first.
// Random bursts of idling on both streams are used before a final clean run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hue_wheel_colormap;
    import hwc_pkg::*;

    localparam int PIPE_LAT    = 28;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_WORDS = 122;
    localparam int TABLE_ROWS  = 24;

    localparam rgb_t COL_BLUE    = '{blue: CHAN_FULL, green: CHAN_OFF,  red: CHAN_OFF};
    localparam rgb_t COL_CYAN    = '{blue: CHAN_FULL, green: CHAN_FULL, red: CHAN_OFF};
    localparam rgb_t COL_GREEN   = '{blue: CHAN_OFF,  green: CHAN_FULL, red: CHAN_OFF};
    localparam rgb_t COL_YELLOW  = '{blue: CHAN_OFF,  green: CHAN_FULL, red: CHAN_FULL};
    localparam rgb_t COL_RED     = '{blue: CHAN_OFF,  green: CHAN_OFF,  red: CHAN_FULL};
    localparam rgb_t COL_MAGENTA = '{blue: CHAN_FULL, green: CHAN_OFF,  red: CHAN_FULL};
    localparam rgb_t COL_NONE    = '{blue: CHAN_OFF,  green: CHAN_OFF,  red: CHAN_OFF};

    // One row of the corner table; a typed color is used when has_color is set.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  count;
        logic                has_color;
        rgb_t                color;
    } corner_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0] cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [COUNT_W-1:0]  s_axis_tdata = '0;  // [15:0] count
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;       // [7:0] red, [15:8] green, [23:16] blue

    // Typed color that travels beside the count word in the corner table.
    logic                typed_on = 1'b0;
    rgb_t                typed_color = '0;

    logic [PERIOD_W-1:0] period_now = PERIOD_RESET;
    bit                  idle_on = 1'b1;
    rgb_t                color_q [$];
    int                  err_cnt = 0;
    int                  words_in = 0;
    int                  colors_out = 0;
    int                  period_writes = 0;
    int                  cycles = 0;
    int                  sink_hold = 0;

    corner_row_t corner_rows [0:TABLE_ROWS-1] = '{
        // After reset, at the default period.
        '{16'd256,   16'd0,     1'b1, COL_BLUE},
        '{16'd256,   16'd256,   1'b1, COL_BLUE},
        '{16'd256,   16'd65535, 1'b0, COL_NONE},
        '{16'd256,   16'd128,   1'b0, COL_NONE},
        '{16'd256,   16'd43,    1'b0, COL_NONE},
        // Period six puts every count on a segment boundary.
        '{16'd6,     16'd1,     1'b1, COL_CYAN},
        '{16'd6,     16'd2,     1'b1, COL_GREEN},
        '{16'd6,     16'd3,     1'b1, COL_YELLOW},
        '{16'd6,     16'd4,     1'b1, COL_RED},
        '{16'd6,     16'd5,     1'b1, COL_MAGENTA},
        '{16'd6,     16'd6,     1'b1, COL_BLUE},
        // Period seven lands mid-ramp in each segment.
        '{16'd7,     16'd1,     1'b0, COL_NONE},
        '{16'd7,     16'd2,     1'b0, COL_NONE},
        '{16'd7,     16'd3,     1'b0, COL_NONE},
        '{16'd7,     16'd4,     1'b0, COL_NONE},
        '{16'd7,     16'd5,     1'b0, COL_NONE},
        '{16'd7,     16'd6,     1'b0, COL_NONE},
        // Smallest periods, including a written zero.
        '{16'd1,     16'd12345, 1'b1, COL_BLUE},
        '{16'd0,     16'd65535, 1'b1, COL_BLUE},
        '{16'd0,     16'd1,     1'b1, COL_BLUE},
        // Largest period.
        '{16'd65535, 16'd65535, 1'b1, COL_BLUE},
        '{16'd65535, 16'd65534, 1'b0, COL_NONE},
        '{16'd65535, 16'd32768, 1'b0, COL_NONE},
        '{16'd65535, 16'd10923, 1'b0, COL_NONE}
    };

    hue_wheel_colormap u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Predicted color of one count on a wheel of the given period.
    function automatic rgb_t hue_color(input logic [COUNT_W-1:0] cnt,
                                       input logic [PERIOD_W-1:0] per);
        int unsigned p;
        int unsigned s;
        int unsigned k;
        int unsigned up;
        int unsigned down;
        rgb_t        c;
        p = (per == '0) ? 1 : int'(per);
        s = 6 * (int'(cnt) % p);
        k = (s <= p) ? 0 : (s - 1) / p;
        up = (255 * (s - k * p)) / p;
        down = (255 * ((k + 1) * p - s)) / p;
        c = '0;
        case (seg_t'(k[2:0]))
            SEG_GREEN_UP:
            begin
                c.blue = CHAN_FULL; c.green = up[7:0]; c.red = CHAN_OFF;
            end
            SEG_BLUE_DOWN:
            begin
                c.blue = down[7:0]; c.green = CHAN_FULL; c.red = CHAN_OFF;
            end
            SEG_RED_UP:
            begin
                c.blue = CHAN_OFF; c.green = CHAN_FULL; c.red = up[7:0];
            end
            SEG_GREEN_DOWN:
            begin
                c.blue = CHAN_OFF; c.green = down[7:0]; c.red = CHAN_FULL;
            end
            SEG_BLUE_UP:
            begin
                c.blue = up[7:0]; c.green = CHAN_OFF; c.red = CHAN_FULL;
            end
            default:
            begin
                c.blue = CHAN_FULL; c.green = CHAN_OFF; c.red = down[7:0];
            end
        endcase
        return c;
    endfunction

    // Random count: mostly uniform, the rest placed around segment boundaries.
    function automatic logic [COUNT_W-1:0] pick_count(input logic [PERIOD_W-1:0] per);
        int unsigned p;
        int unsigned r;
        int unsigned b;
        int unsigned m;
        logic [31:0] full;
        p = (per == '0) ? 1 : int'(per);
        if ($urandom_range(0, 3) != 0)
            return COUNT_W'($urandom);
        b = $urandom_range(0, 6);
        r = (b * p + 5) / 6 + $urandom_range(0, 2);
        r = (r + p - 1) % p;
        m = $urandom_range(0, 65535 / p);
        full = m * p + r;
        return full[COUNT_W-1:0];
    endfunction

    function automatic void check_chan(input string name, input logic [CHAN_W-1:0] want,
                                       input logic [CHAN_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Offer one count word and hold it until it is taken.
    task automatic send_count(input logic [COUNT_W-1:0] cnt, input logic has_col,
                              input rgb_t col);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cnt;
        typed_on      <= has_col;
        typed_color   <= col;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Let the pipeline empty, then write a new period.
    task automatic set_period(input logic [PERIOD_W-1:0] per);
        s_axis_tvalid <= 1'b0;
        while (color_q.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= per;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        period_now   = per;
        period_writes++;
    endtask

    // Output side: random stall bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rst_n && idle_on && $urandom_range(0, 4) == 0)
        begin
            sink_hold     <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Record each accepted count and compare each accepted color.
    always @(posedge clk)
    begin : scoreboard
        rgb_t want;
        rgb_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                color_q.insert(color_q.size(),
                               typed_on ? typed_color : hue_color(s_axis_tdata, period_now));
                words_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                colors_out++;
                if (color_q.size() == 0)
                begin
                    $display("%0t ns: unexpected color word, expected none, actual %06h",
                             $time, got);
                    err_cnt++;
                end
                else
                begin
                    want = color_q.pop_front();
                    check_chan("red",   want.red,   got.red);
                    check_chan("green", want.green, got.green);
                    check_chan("blue",  want.blue,  got.blue);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d colors outstanding.",
                     cycles, color_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [PERIOD_W-1:0] per;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner table.
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            if (corner_rows[i].period != period_now)
                set_period(corner_rows[i].period);
            send_count(corner_rows[i].count, corner_rows[i].has_color, corner_rows[i].color);
        end
        typed_on <= 1'b0;

        // Random phases, each at its own period; the last one without idling.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: per = 16'd3;
                1: per = 16'd65535;
                2: per = 16'($urandom_range(2, 64));
                3: per = 16'd0;
                4: per = 16'd2;
                5: per = 16'($urandom_range(1000, 65534));
                6: per = 16'd1;
                7: per = 16'($urandom_range(65, 999));
                default: per = 16'($urandom);
            endcase
            if (ph == RAND_PHASES - 1)
                idle_on = 1'b0;
            set_period(per);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_count(pick_count(period_now), 1'b0, COL_NONE);
        end
        s_axis_tvalid <= 1'b0;

        while (color_q.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("Ran %0d count words through %0d period settings (%0d writes).",
                 words_in, period_writes + 1, period_writes);
        $display("Compared %0d colors, %0d mismatches.", colors_out, err_cnt);
        if (err_cnt == 0 && color_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hwc_pkg.sv
rtl/core/hwc_mod.sv
rtl/core/hwc_div.sv
rtl/core/hue_wheel_colormap.sv
rtl/core/hwc_checker.sv
bench/tb_hue_wheel_colormap.sv
